[hdl/peq_pkg.sv]
`default_nettype none

package peq_pkg;

  // Sample and coefficient widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;

  // Output history is Q32.16, split into a signed high word and an unsigned low half
  localparam int YH_W     = 48;
  localparam int LO_W     = 16;

  // One history entry holds {x, y} of one tap of one channel
  localparam int ENTRY_W    = SAMPLE_W + YH_W;
  localparam int HIST_DEPTH = 4;
  localparam int HIST_AW    = 2;

  // Shared multiplier: coefficient times a 33-bit signed operand
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = COEF_W + MUL_B_W;

  // Product accumulator and bandpass sum widths
  localparam int ACC_W = 81;
  localparam int Y_W   = 54;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_COEF_A = 3'd1;
  localparam logic [2:0] REG_COEF_B = 3'd2;
  localparam logic [2:0] REG_COEF_G = 3'd3;
  localparam logic [2:0] REG_LEVEL  = 3'd4;

  // Saturation bounds
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [YH_W-1:0]     YH_MAX     = {1'b0, {(YH_W-1){1'b1}}};
  localparam logic signed [YH_W-1:0]     YH_MIN     = {1'b1, {(YH_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       channel_sel;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/peq_stream_if.sv]
`default_nettype none

interface peq_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[hdl/peq_ram.sv]
`default_nettype none

module peq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/peq_mul.sv]
`default_nettype none

module peq_mul (
  input  wire logic                               clk,
  input  wire logic signed [peq_pkg::COEF_W-1:0]  a,
  input  wire logic signed [peq_pkg::MUL_B_W-1:0] b,
  output logic signed      [peq_pkg::PROD_W-1:0]  p
);

  import peq_pkg::*;

  // Register the product before it is used
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

[hdl/peaking_eq_biquad_filter.sv]
// Channel   Dir  Payload                         Handshake
// in_ch     in   sample_in[15:0], channel_sel    valid / ready
// out_ch    out  sample_out[15:0]                valid / ready
// APB       in   filter_enable, coef_a/b/g, level_gain at 4*index
//
// Filtering is paced by the single 32x33 multiplier, which takes seven passes
// (a*dx, g*y1, b*y2 and level*y in high and low halves), and by the two reads and two
// writes of the history RAM. Bypass goes from idle straight to the output stage.
// One transaction is in work at a time.
// Reset clears configuration, state, history valid bits and output valid; the history
// RAM needs no sweep. A stalled output holds the block in its last state.
`default_nettype none

module peaking_eq_biquad_filter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  peq_stream_if.sink                      in_ch,
  peq_stream_if.source                    out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [peq_pkg::CFG_AW-1:0] paddr,
  input  wire logic [peq_pkg::CFG_DW-1:0] pwdata,
  output logic      [peq_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  import peq_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD_OLD = 4'd1;
  localparam logic [3:0] ST_RD_NEW = 4'd2;
  localparam logic [3:0] ST_MUL_A  = 4'd3;
  localparam logic [3:0] ST_MUL_GH = 4'd4;
  localparam logic [3:0] ST_MUL_GL = 4'd5;
  localparam logic [3:0] ST_MUL_BH = 4'd6;
  localparam logic [3:0] ST_MUL_BL = 4'd7;
  localparam logic [3:0] ST_ACC_B  = 4'd8;
  localparam logic [3:0] ST_SUB_B  = 4'd9;
  localparam logic [3:0] ST_SAT    = 4'd10;
  localparam logic [3:0] ST_MUL_LH = 4'd11;
  localparam logic [3:0] ST_MUL_LL = 4'd12;
  localparam logic [3:0] ST_ACC_L  = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  logic [3:0] state, state_next;

  // Configuration registers
  logic                     filter_enable;
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_g, level_gain;
  logic                     cfg_we;
  logic [2:0]               cfg_idx;

  // History valid bits, one per RAM entry
  logic [HIST_DEPTH-1:0] hist_valid;

  // Transaction registers
  logic signed [SAMPLE_W-1:0] x, x1;
  logic                       ch;
  logic                       filt;
  logic signed [SAMPLE_W:0]   d;
  logic signed [YH_W-1:0]     y1, y2, ysat;
  logic signed [Y_W-1:0]      y;
  logic signed [ACC_W-1:0]    acc;

  // Multiplier
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // History RAM
  logic               ram_we, ram_re;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata, rd_entry;
  logic               rd_valid;
  logic signed [SAMPLE_W-1:0] rd_x;
  logic signed [YH_W-1:0]     rd_y;

  // Result
  logic                       in_acc, out_load, out_valid;
  out_item_t                  out_data;
  logic signed [YH_W-1:0]     y_sat_c;
  logic signed [ACC_W-40-1:0] q_round;
  logic signed [SAMPLE_W-1:0] q_sat, result;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      coef_a        <= '0;
      coef_b        <= '0;
      coef_g        <= '0;
      level_gain    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE: filter_enable <= pwdata[0];
        REG_COEF_A: coef_a        <= pwdata;
        REG_COEF_B: coef_b        <= pwdata;
        REG_COEF_G: coef_g        <= pwdata;
        REG_LEVEL:  level_gain    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE: prdata = {{(CFG_DW-1){1'b0}}, filter_enable};
      REG_COEF_A: prdata = coef_a;
      REG_COEF_B: prdata = coef_b;
      REG_COEF_G: prdata = coef_g;
      REG_LEVEL:  prdata = level_gain;
      default:    prdata = '0;
    endcase
  end

  // Drop all history on every enable write that sets the enable bit; mark entries as they are written
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (cfg_we && (cfg_idx == REG_ENABLE) && pwdata[0]) begin
      hist_valid <= '0;
    end else if (ram_we) begin
      hist_valid[ram_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && (state == ST_IDLE);
  assign out_load    = (state == ST_OUT) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid) state_next = filter_enable ? ST_RD_OLD : ST_OUT;
      ST_RD_OLD: state_next = ST_RD_NEW;
      ST_RD_NEW: state_next = ST_MUL_A;
      ST_MUL_A:  state_next = ST_MUL_GH;
      ST_MUL_GH: state_next = ST_MUL_GL;
      ST_MUL_GL: state_next = ST_MUL_BH;
      ST_MUL_BH: state_next = ST_MUL_BL;
      ST_MUL_BL: state_next = ST_ACC_B;
      ST_ACC_B:  state_next = ST_SUB_B;
      ST_SUB_B:  state_next = ST_SAT;
      ST_SAT:    state_next = ST_MUL_LH;
      ST_MUL_LH: state_next = ST_MUL_LL;
      ST_MUL_LL: state_next = ST_ACC_L;
      ST_ACC_L:  state_next = ST_OUT;
      ST_OUT:    if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // History RAM access: read x[n-2]/y[n-2], then x[n-1]/y[n-1]; write back shifted
  always_comb begin
    ram_re    = (state == ST_RD_OLD) || (state == ST_RD_NEW);
    ram_raddr = (state == ST_RD_OLD) ? {ch, 1'b1} : {ch, 1'b0};
    ram_we    = (state == ST_SAT) || (state == ST_MUL_LH);
    ram_waddr = (state == ST_SAT) ? {ch, 1'b1} : {ch, 1'b0};
    ram_wdata = (state == ST_SAT) ? {x1, y1} : {x, ysat};
  end

  // Entries never written since the last clear read as zero
  assign rd_valid = (state == ST_RD_NEW) ? hist_valid[{ch, 1'b1}] : hist_valid[{ch, 1'b0}];
  assign rd_entry = rd_valid ? ram_rdata : '0;
  assign rd_x     = rd_entry[ENTRY_W-1:YH_W];
  assign rd_y     = rd_entry[YH_W-1:0];

  peq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Multiplier operand select: high words signed, low halves zero extended
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_A: begin
        mul_a = coef_a;
        mul_b = MUL_B_W'(d);
      end
      ST_MUL_GH: begin
        mul_a = coef_g;
        mul_b = MUL_B_W'($signed(y1[YH_W-1:LO_W]));
      end
      ST_MUL_GL: begin
        mul_a = coef_g;
        mul_b = {{(MUL_B_W-LO_W){1'b0}}, y1[LO_W-1:0]};
      end
      ST_MUL_BH: begin
        mul_a = coef_b;
        mul_b = MUL_B_W'($signed(y2[YH_W-1:LO_W]));
      end
      ST_MUL_BL: begin
        mul_a = coef_b;
        mul_b = {{(MUL_B_W-LO_W){1'b0}}, y2[LO_W-1:0]};
      end
      ST_MUL_LH: begin
        mul_a = level_gain;
        mul_b = MUL_B_W'($signed(ysat[YH_W-1:LO_W]));
      end
      ST_MUL_LL: begin
        mul_a = level_gain;
        mul_b = {{(MUL_B_W-LO_W){1'b0}}, ysat[LO_W-1:0]};
      end
      default: ;
    endcase
  end

  peq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Saturate the bandpass sum to the 48-bit history range
  always_comb begin
    if (y > Y_W'(YH_MAX)) begin
      y_sat_c = YH_MAX;
    end else if (y < Y_W'(YH_MIN)) begin
      y_sat_c = YH_MIN;
    end else begin
      y_sat_c = y[YH_W-1:0];
    end
  end

  // Datapath: each product is accumulated exactly, then floored to Q.16
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          x    <= in_ch.payload.sample_in;
          ch   <= in_ch.payload.channel_sel;
          filt <= filter_enable;
        end
      end
      ST_RD_NEW: begin
        d  <= (SAMPLE_W+1)'(x) - (SAMPLE_W+1)'(rd_x);
        y2 <= rd_y;
      end
      ST_MUL_A: begin
        x1 <= rd_x;
        y1 <= rd_y;
      end
      ST_MUL_GH: y <= Y_W'(prod >>> 14);
      ST_MUL_GL: acc <= ACC_W'(prod) <<< LO_W;
      ST_MUL_BH: acc <= acc + ACC_W'(prod);
      ST_MUL_BL: begin
        y   <= y + Y_W'(acc >>> 29);
        acc <= ACC_W'(prod) <<< LO_W;
      end
      ST_ACC_B:  acc <= acc + ACC_W'(prod);
      ST_SUB_B:  y <= y - Y_W'(acc >>> 29);
      ST_SAT:    ysat <= y_sat_c;
      ST_MUL_LL: acc <= (ACC_W'(prod) <<< LO_W) + (ACC_W'(x) <<< 40);
      ST_ACC_L:  acc <= acc + ACC_W'(prod);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output: truncate x + y*level toward zero, then saturate to 16 bits
  assign q_round = acc[ACC_W-1:40] + 41'((acc[ACC_W-1] && (acc[39:0] != '0)) ? 1 : 0);

  always_comb begin
    if (q_round > 41'(SAMPLE_MAX)) begin
      q_sat = SAMPLE_MAX;
    end else if (q_round < 41'(SAMPLE_MIN)) begin
      q_sat = SAMPLE_MIN;
    end else begin
      q_sat = q_round[SAMPLE_W-1:0];
    end
  end

  assign result = filt ? q_sat : x;

  // Output register: hold the transaction until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.sample_out <= result;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  // ---------------------------------------------------------------------------
  // Assertions

  // A bypassed transaction goes straight to the output stage
  a_bypass_path: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !filter_enable) |=> (state == ST_OUT))
    else $error("bypass transaction did not go to output stage");

  // A filtered transaction reaches the output stage after a fixed schedule
  a_filter_latency: assert property (@(posedge clk) disable iff (rst)
    (in_acc && filter_enable) |=> ##13 (state == ST_OUT))
    else $error("filter schedule length broken");

  // New output data only comes from the output stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("output valid rose outside output stage");

  // History is read and written in separate phases of a transaction
  a_ram_phases: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re && !in_ch.ready)
    else $error("history RAM write overlaps a read or idle");

endmodule

`default_nettype wire
